/* rtl/core/tba_pkg.sv */
// Package for the tiered bump allocator: field widths, codes, reset values
// and the configuration bundle shared by the register file and the allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tba_pkg;

	localparam int unsigned SIZE_W       = 32;
	localparam int unsigned SEL_W        = 3;
	localparam int unsigned MED_W        = 2;
	localparam int unsigned BASE_W       = 48;
	localparam int unsigned GRANT_W      = 48;
	localparam int unsigned ADDR_BITS    = 48;
	localparam int unsigned THRESH_W     = 32;
	localparam int unsigned ALIGN_LOG2   = 8;
	localparam int unsigned ALIGN_BYTES  = 1 << ALIGN_LOG2;
	localparam int unsigned NUM_MEDIA    = 4;
	localparam int unsigned PDATA_W      = 64;
	localparam int unsigned PADDR_W      = 6;
	localparam int unsigned REG_SHIFT    = 3;
	localparam int unsigned REG_IDX_W    = PADDR_W - REG_SHIFT;

	typedef enum logic [MED_W-1:0] {
		MED_FAST    = 2'd0,
		MED_BULK    = 2'd1,
		MED_STORAGE = 2'd2,
		MED_LEGACY  = 2'd3
	} medium_t;

	typedef enum logic [SEL_W-1:0] {
		SEL_FAST    = 3'd0,
		SEL_BULK    = 3'd1,
		SEL_STORAGE = 3'd2,
		SEL_LEGACY  = 3'd3,
		SEL_POLICY  = 3'd4
	} select_t;

	typedef enum logic [1:0] {
		MODE_FAST      = 2'd0,
		MODE_BULK      = 2'd1,
		MODE_STORAGE   = 2'd2,
		MODE_THRESHOLD = 2'd3
	} mode_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MODE         = 3'd0,
		REG_THRESHOLD    = 3'd1,
		REG_FAST_BASE    = 3'd2,
		REG_BULK_BASE    = 3'd3,
		REG_STORAGE_BASE = 3'd4
	} reg_idx_t;

	localparam logic [BASE_W-1:0] FAST_BASE_RST    = 48'h0;
	localparam logic [BASE_W-1:0] BULK_BASE_RST    = 48'h0004_0000_0000;
	localparam logic [BASE_W-1:0] STORAGE_BASE_RST = 48'h0008_0000_0000;

	typedef struct packed {
		mode_t               mode;
		logic [THRESH_W-1:0] threshold;
		logic [BASE_W-1:0]   fast_base;
		logic [BASE_W-1:0]   bulk_base;
		logic [BASE_W-1:0]   storage_base;
	} cfg_t;

endpackage
`default_nettype wire

/* rtl/core/tiered_bump_allocator.sv */
// Top level of the tiered bump allocator: request register, result register
// and handshake control around tba_regs and tba_alloc. Depends on tba_pkg.
//
//   Channel   Direction  Handshake            Payload
//   request   in         in_valid / in_stall  alloc_size, medium_select
//   grant     out        out_valid / out_stall granted_address, medium_used
//   config    in         APB psel/penable     paddr, pwdata, prdata
//
// A request is taken into the request register; once the result register is free,
// the grant is computed from the selected region cursor and written to the result
// register while that cursor advances. One request per cycle is sustained while
// the grant is not stalled. A stalled grant holds the result register, and the
// request register keeps taking a transaction until it too is full. Reset clears
// all cursors and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module tiered_bump_allocator (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire  [tba_pkg::SIZE_W-1:0]   alloc_size,
	input  wire  [tba_pkg::SEL_W-1:0]    medium_select,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [tba_pkg::GRANT_W-1:0]  granted_address,
	output logic [tba_pkg::MED_W-1:0]    medium_used,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [tba_pkg::PADDR_W-1:0]  paddr,
	input  wire  [tba_pkg::PDATA_W-1:0]  pwdata,
	output logic [tba_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);

	tba_pkg::cfg_t                  cfg;
	logic                           cursor_clr;
	logic                           valid_s1;
	logic [tba_pkg::SIZE_W-1:0]     size_s1;
	logic [tba_pkg::SEL_W-1:0]      sel_s1;
	logic                           out_valid_q;
	logic [tba_pkg::GRANT_W-1:0]    granted_q;
	tba_pkg::medium_t               medium_q;
	logic                           out_free;
	logic                           go_s1;
	logic                           in_take;
	logic [tba_pkg::GRANT_W-1:0]    grant_c;
	tba_pkg::medium_t               medium_c;

	tba_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.cfg        (cfg),
		.cursor_clr (cursor_clr)
	);

	tba_alloc u_alloc (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cursor_clr (cursor_clr),
		.step       (go_s1),
		.size       (size_s1),
		.sel        (sel_s1),
		.granted    (grant_c),
		.region     (medium_c)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign go_s1    = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= in_take || (valid_s1 && !out_free);
			out_valid_q <= go_s1 || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			size_s1 <= alloc_size;
			sel_s1  <= medium_select;
		end
		if (go_s1) begin
			granted_q <= grant_c;
			medium_q  <= medium_c;
		end
	end

	assign out_valid       = out_valid_q;
	assign granted_address = granted_q;
	assign medium_used     = medium_q;

endmodule
`default_nettype wire

/* rtl/core/tba_regs.sv */
// Configuration register file behind the APB-style port.
// Depends on tba_pkg; raises a one-cycle clear for the cursors on every write to a defined register.
`timescale 1ns / 1ps
`default_nettype none
module tba_regs (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [tba_pkg::PADDR_W-1:0]  paddr,
	input  wire  [tba_pkg::PDATA_W-1:0]  pwdata,
	output logic [tba_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output tba_pkg::cfg_t                cfg,
	output logic                         cursor_clr
);

	tba_pkg::cfg_t                     cfg_q;
	logic                              wr_en;
	logic [tba_pkg::REG_IDX_W-1:0]     idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[tba_pkg::PADDR_W-1:tba_pkg::REG_SHIFT];
	assign cfg    = cfg_q;

	always_comb begin
		cursor_clr = 1'b0;
		if (wr_en) begin
			unique case (tba_pkg::reg_idx_t'(idx))
				tba_pkg::REG_MODE,
				tba_pkg::REG_THRESHOLD,
				tba_pkg::REG_FAST_BASE,
				tba_pkg::REG_BULK_BASE,
				tba_pkg::REG_STORAGE_BASE: cursor_clr = 1'b1;
				default:                   cursor_clr = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode         <= tba_pkg::MODE_THRESHOLD;
			cfg_q.threshold    <= '0;
			cfg_q.fast_base    <= tba_pkg::FAST_BASE_RST;
			cfg_q.bulk_base    <= tba_pkg::BULK_BASE_RST;
			cfg_q.storage_base <= tba_pkg::STORAGE_BASE_RST;
		end else if (wr_en) begin
			unique case (tba_pkg::reg_idx_t'(idx))
				tba_pkg::REG_MODE:
					cfg_q.mode <= tba_pkg::mode_t'(pwdata[1:0]);
				tba_pkg::REG_THRESHOLD:
					cfg_q.threshold <= pwdata[tba_pkg::THRESH_W-1:0];
				tba_pkg::REG_FAST_BASE:
					cfg_q.fast_base <= pwdata[tba_pkg::BASE_W-1:0];
				tba_pkg::REG_BULK_BASE:
					cfg_q.bulk_base <= pwdata[tba_pkg::BASE_W-1:0];
				tba_pkg::REG_STORAGE_BASE:
					cfg_q.storage_base <= pwdata[tba_pkg::BASE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (tba_pkg::reg_idx_t'(idx))
			tba_pkg::REG_MODE:
				prdata = tba_pkg::PDATA_W'(cfg_q.mode);
			tba_pkg::REG_THRESHOLD:
				prdata = tba_pkg::PDATA_W'(cfg_q.threshold);
			tba_pkg::REG_FAST_BASE:
				prdata = tba_pkg::PDATA_W'(cfg_q.fast_base);
			tba_pkg::REG_BULK_BASE:
				prdata = tba_pkg::PDATA_W'(cfg_q.bulk_base);
			tba_pkg::REG_STORAGE_BASE:
				prdata = tba_pkg::PDATA_W'(cfg_q.storage_base);
			default:
				prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

/* rtl/core/tba_alloc.sv */
// Region choice, aligned grant computation and the four region cursors.
// Depends on tba_pkg; a step advances the selected cursor, a clear zeroes all four.
`timescale 1ns / 1ps
`default_nettype none
module tba_alloc (
	input  wire                           clk,
	input  wire                           arst_n,
	input  tba_pkg::cfg_t                 cfg,
	input  wire                           cursor_clr,
	input  wire                           step,
	input  wire  [tba_pkg::SIZE_W-1:0]    size,
	input  wire  [tba_pkg::SEL_W-1:0]     sel,
	output logic [tba_pkg::GRANT_W-1:0]   granted,
	output tba_pkg::medium_t              region
);

	localparam logic [tba_pkg::ADDR_BITS-1:0] ALIGN_MASK =
		tba_pkg::ADDR_BITS'(tba_pkg::ALIGN_BYTES - 1);

	logic [tba_pkg::ADDR_BITS-1:0]   cursor_q [tba_pkg::NUM_MEDIA];
	tba_pkg::medium_t                policy_med;
	logic [tba_pkg::BASE_W-1:0]      base_sel;
	logic [tba_pkg::ADDR_BITS-1:0]   base_a;
	logic [tba_pkg::ADDR_BITS-1:0]   cur;
	logic [tba_pkg::ADDR_BITS-1:0]   start;
	logic [tba_pkg::ADDR_BITS-1:0]   grant_a;
	logic [tba_pkg::ALIGN_LOG2-1:0]  pad;
	logic [tba_pkg::ADDR_BITS-1:0]   next_raw;
	logic [tba_pkg::ADDR_BITS-1:0]   next_cur;

	always_comb begin
		unique case (cfg.mode)
			tba_pkg::MODE_FAST:    policy_med = tba_pkg::MED_FAST;
			tba_pkg::MODE_BULK:    policy_med = tba_pkg::MED_BULK;
			tba_pkg::MODE_STORAGE: policy_med = tba_pkg::MED_STORAGE;
			tba_pkg::MODE_THRESHOLD:
				policy_med = (cfg.threshold != '0 && size >= cfg.threshold)
					? tba_pkg::MED_STORAGE : tba_pkg::MED_FAST;
			default:               policy_med = tba_pkg::MED_FAST;
		endcase
	end

	always_comb begin
		unique case (tba_pkg::select_t'(sel))
			tba_pkg::SEL_FAST:    region = tba_pkg::MED_FAST;
			tba_pkg::SEL_BULK:    region = tba_pkg::MED_BULK;
			tba_pkg::SEL_STORAGE: region = tba_pkg::MED_STORAGE;
			tba_pkg::SEL_LEGACY:  region = tba_pkg::MED_LEGACY;
			tba_pkg::SEL_POLICY:  region = policy_med;
			default:              region = tba_pkg::MED_LEGACY;
		endcase
	end

	always_comb begin
		unique case (region)
			tba_pkg::MED_FAST:    base_sel = cfg.fast_base;
			tba_pkg::MED_BULK:    base_sel = cfg.bulk_base;
			tba_pkg::MED_STORAGE: base_sel = cfg.storage_base;
			tba_pkg::MED_LEGACY:  base_sel = '0;
			default:              base_sel = '0;
		endcase
	end

	assign base_a     = base_sel;
	assign cur        = cursor_q[region];
	assign start      = base_a + cur;
	assign grant_a    = (start + ALIGN_MASK) & ~ALIGN_MASK;
	assign pad        = tba_pkg::ALIGN_LOG2'(0) - start[tba_pkg::ALIGN_LOG2-1:0];
	assign next_raw   = cur + tba_pkg::ADDR_BITS'(size) + tba_pkg::ADDR_BITS'(pad);
	assign next_cur   = (next_raw + ALIGN_MASK) & ~ALIGN_MASK;
	assign granted    = grant_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tba_pkg::NUM_MEDIA; i++) begin
				cursor_q[i] <= '0;
			end
		end else if (cursor_clr) begin
			for (int i = 0; i < tba_pkg::NUM_MEDIA; i++) begin
				cursor_q[i] <= '0;
			end
		end else if (step) begin
			cursor_q[region] <= next_cur;
		end
	end

endmodule
`default_nettype wire
